FILE: hw/rtl/triangle_tangent_gram_schmidt_unit_defines.svh
// Assertion macros for the triangle tangent unit.
// Used by ttgs_alu and triangle_tangent_gram_schmidt_unit.
`ifndef TRIANGLE_TANGENT_GRAM_SCHMIDT_UNIT_DEFINES_SVH
`define TRIANGLE_TANGENT_GRAM_SCHMIDT_UNIT_DEFINES_SVH

// same-cycle implication
`define TTGS_AST_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTGS_AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ttgs_pkg.sv
// Shared types and constants for the triangle tangent unit.
// No dependencies.
package ttgs_pkg;

   localparam int POS_W         = 32;
   localparam int EDGE_W        = POS_W + 1;
   localparam int NRM_W         = 16;
   localparam int TAN_W         = 32;
   localparam int ROOT_W        = 32;
   localparam int ACC_W         = 70;
   localparam int MAG_W         = 68;
   localparam int OPB_W         = 34;
   localparam int SQRT_N        = 32;
   localparam int SQRT_TOP      = 62;
   localparam int DIV_N         = 64;
   localparam int CNT_W         = 6;
   localparam int TOP_BITS      = 30;
   localparam int NORM_FRAC_DEF = 14;

   typedef enum logic [1:0] {
      ALU_MAC,
      ALU_SQRT,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
      logic       sub;
   } alu_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DET,
      S_TAN,
      S_SHIFT,
      S_SQ,
      S_SQRT,
      S_DIV,
      S_PROJ,
      S_WORTH,
      S_OUT
   } seq_state_type;

endpackage

FILE: hw/rtl/ttgs_if.sv
// Valid/ready channels of the triangle tangent unit: vertex in, tangent out.
// No dependencies.
interface ttgs_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] tex_u;
   logic signed [31:0] tex_v;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                   norm_x, norm_y, norm_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v,
                 norm_x, norm_y, norm_z, output ready);
endinterface

interface ttgs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] tan_x;
   logic signed [15:0] tan_y;
   logic signed [15:0] tan_z;
   logic [1:0]         corner;
   logic               last_of_triangle;

   modport source (output valid, tan_x, tan_y, tan_z, corner, last_of_triangle,
                   input ready);
   modport sink (input valid, tan_x, tan_y, tan_z, corner, last_of_triangle,
                 output ready);
endinterface

FILE: hw/rtl/triangle_tangent_gram_schmidt_unit.sv
// Channel  Dir  Payload                               Handshake
// req_bus  in   pos_x/y/z, tex_u/v, norm_x/y/z         valid/ready
// rsp_bus  out  tan_x/y/z, corner, last_of_triangle    valid/ready
// First two vertices of a triangle are stored in the idle state. The third vertex
// starts the computation on the bit-serial shared unit (MAC, root, divide), with
// result transfers in between. req ready only when idle; the sequencer holds at each
// tangent until rsp transfer. Synchronous reset clears control only.
// Depends on ttgs_pkg, ttgs_if, ttgs_alu and the defines header.
`include "triangle_tangent_gram_schmidt_unit_defines.svh"

module triangle_tangent_gram_schmidt_unit #(
   parameter int NORM_FRAC_BITS = ttgs_pkg::NORM_FRAC_DEF
) (
   input logic        clock,
   input logic        reset,
   ttgs_req_if.sink   req_bus,
   ttgs_rsp_if.source rsp_bus
);
   import ttgs_pkg::*;

   seq_state_type state_ff, state_in;
   logic [1:0]    vcnt_ff, vcnt_in;
   logic          issued_ff, issued_in;
   logic [1:0]    idx_ff, idx_in;
   logic          half_ff, half_in;
   logic          phase_ff, phase_in;
   logic [1:0]    k_ff, k_in;

   logic signed [POS_W-1:0]  hpos_ff [6];
   logic signed [POS_W-1:0]  hpos_in [6];
   logic signed [POS_W-1:0]  huv_ff [4];
   logic signed [POS_W-1:0]  huv_in [4];
   logic signed [NRM_W-1:0]  hnrm_ff [6];
   logic signed [NRM_W-1:0]  hnrm_in [6];
   logic signed [NRM_W-1:0]  n2_ff [3];
   logic signed [NRM_W-1:0]  n2_in [3];
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e1_in [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] e2_in [3];
   logic signed [EDGE_W-1:0] du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [EDGE_W-1:0] du2_ff, du2_in, dv2_ff, dv2_in;
   logic                     dneg_ff, dneg_in;
   logic [ACC_W-1:0]         run_ff, run_in;
   logic [ACC_W-1:0]         proj_ff, proj_in;
   logic [MAG_W-1:0]         mag_ff [3];
   logic [MAG_W-1:0]         mag_in [3];
   logic                     neg_ff [3];
   logic                     neg_in [3];
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic signed [TAN_W-1:0]  tu_ff [3];
   logic signed [TAN_W-1:0]  tu_in [3];
   logic signed [NRM_W-1:0]  res_ff [3];
   logic signed [NRM_W-1:0]  res_in [3];

   alu_req_type      alu_req;
   alu_sts_type      alu_sts;
   logic [ACC_W-1:0] alu_opa, alu_opb, alu_init, alu_res;

   logic signed [POS_W-1:0] in_pos [3];
   logic signed [NRM_W-1:0] in_nrm [3];
   logic signed [NRM_W-1:0] nk [3];
   logic [ACC_W-1:0]        res_abs;
   logic                    res_neg;
   logic [MAG_W-1:0]        orv;
   logic                    req_xfer, rsp_xfer, alu_done, last_idx;
   logic [TAN_W-1:0]        qt;
   logic [NRM_W-1:0]        qn;

   ttgs_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .opa     (alu_opa),
      .opb     (alu_opb),
      .init    (alu_init),
      .result  (alu_res),
      .alu_sts (alu_sts)
   );

   assign in_pos[0] = req_bus.pos_x;
   assign in_pos[1] = req_bus.pos_y;
   assign in_pos[2] = req_bus.pos_z;
   assign in_nrm[0] = req_bus.norm_x;
   assign in_nrm[1] = req_bus.norm_y;
   assign in_nrm[2] = req_bus.norm_z;

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_xfer = rsp_bus.valid && rsp_bus.ready;
   assign alu_done = alu_sts.done;
   assign last_idx = idx_ff == 2'd2;
   assign res_neg  = alu_res[ACC_W-1];
   assign res_abs  = res_neg ? -alu_res : alu_res;
   assign orv      = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign qt       = alu_res[TAN_W-1:0];
   assign qn       = alu_res[NRM_W-1:0];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (k_ff)
            2'd0:    nk[c] = hnrm_ff[c];
            2'd1:    nk[c] = hnrm_ff[3+c];
            default: nk[c] = n2_ff[c];
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_xfer && vcnt_ff == 2'd2) state_in = S_DET;
         S_DET: begin
            if (alu_done && half_ff) state_in = (alu_res == '0) ? S_PROJ : S_TAN;
         end
         S_TAN:   if (alu_done && half_ff && last_idx) state_in = S_SHIFT;
         S_SHIFT: begin
            if (orv == '0) state_in = phase_ff ? S_PROJ : S_OUT;
            else if (!(|orv[MAG_W-1:TOP_BITS]) && orv[TOP_BITS-1]) state_in = S_SQ;
         end
         S_SQ:    if (alu_done && last_idx) state_in = S_SQRT;
         S_SQRT:  if (alu_done) state_in = S_DIV;
         S_DIV:   if (alu_done && last_idx) state_in = phase_ff ? S_PROJ : S_OUT;
         S_PROJ:  if (alu_done && last_idx) state_in = S_WORTH;
         S_WORTH: if (alu_done && last_idx) state_in = S_SHIFT;
         S_OUT:   if (rsp_xfer) state_in = (k_ff == 2'd2) ? S_IDLE : S_PROJ;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and unit requests
   always_comb begin
      req_bus.ready = state_ff == S_IDLE;
      rsp_bus.valid = state_ff == S_OUT;
      alu_req.start = 1'b0;
      alu_req.op    = ALU_MAC;
      alu_req.sub   = 1'b0;
      alu_opa       = '0;
      alu_opb       = '0;
      alu_init      = '0;
      case (state_ff)
         S_DET: begin
            alu_req.start = !issued_ff;
            alu_req.sub   = half_ff;
            alu_opa       = half_ff ? ACC_W'(du2_ff) : ACC_W'(du1_ff);
            alu_opb       = half_ff ? ACC_W'(dv1_ff) : ACC_W'(dv2_ff);
            alu_init      = half_ff ? run_ff : '0;
         end
         S_TAN: begin
            alu_req.start = !issued_ff;
            alu_req.sub   = half_ff;
            alu_opa       = half_ff ? ACC_W'(dv1_ff) : ACC_W'(dv2_ff);
            alu_opb       = half_ff ? ACC_W'(e2_ff[idx_ff]) : ACC_W'(e1_ff[idx_ff]);
            alu_init      = half_ff ? run_ff : '0;
         end
         S_SQ: begin
            alu_req.start = !issued_ff;
            alu_opa       = ACC_W'(mag_ff[idx_ff]);
            alu_opb       = ACC_W'(mag_ff[idx_ff]);
            alu_init      = (idx_ff == 2'd0) ? '0 : run_ff;
         end
         S_SQRT: begin
            alu_req.start = !issued_ff;
            alu_req.op    = ALU_SQRT;
            alu_opa       = run_ff;
         end
         S_DIV: begin
            alu_req.start = !issued_ff;
            alu_req.op    = ALU_DIV;
            alu_opa       = phase_ff
               ? (ACC_W'(mag_ff[idx_ff]) << (TOP_BITS + 1)) + ACC_W'(root_ff)
               : (ACC_W'(mag_ff[idx_ff]) << (NORM_FRAC_BITS + 1)) + ACC_W'(root_ff);
            alu_opb       = ACC_W'(root_ff) << 1;
         end
         S_PROJ: begin
            alu_req.start = !issued_ff;
            alu_opa       = ACC_W'(tu_ff[idx_ff]);
            alu_opb       = ACC_W'(nk[idx_ff]);
            alu_init      = (idx_ff == 2'd0) ? '0 : run_ff;
         end
         S_WORTH: begin
            alu_req.start = !issued_ff;
            alu_req.sub   = 1'b1;
            alu_opa       = proj_ff;
            alu_opb       = ACC_W'(nk[idx_ff]);
            alu_init      = ACC_W'(tu_ff[idx_ff]) << (2 * NORM_FRAC_BITS);
         end
         default: ;
      endcase
      rsp_bus.tan_x            = res_ff[0];
      rsp_bus.tan_y            = res_ff[1];
      rsp_bus.tan_z            = res_ff[2];
      rsp_bus.corner           = k_ff;
      rsp_bus.last_of_triangle = k_ff == 2'd2;
   end

   // sequencer counters and datapath
   always_comb begin
      vcnt_in   = vcnt_ff;
      issued_in = issued_ff;
      idx_in    = idx_ff;
      half_in   = half_ff;
      phase_in  = phase_ff;
      k_in      = k_ff;
      hpos_in   = hpos_ff;
      huv_in    = huv_ff;
      hnrm_in   = hnrm_ff;
      n2_in     = n2_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      du1_in    = du1_ff;
      dv1_in    = dv1_ff;
      du2_in    = du2_ff;
      dv2_in    = dv2_ff;
      dneg_in   = dneg_ff;
      run_in    = run_ff;
      proj_in   = proj_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      root_in   = root_ff;
      tu_in     = tu_ff;
      res_in    = res_ff;

      if (alu_req.start) issued_in = 1'b1;
      if (alu_done) issued_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (vcnt_ff == 2'd2) begin
                  vcnt_in = 2'd0;
                  for (int c = 0; c < 3; c++) begin
                     e1_in[c] = EDGE_W'(hpos_ff[3+c]) - EDGE_W'(hpos_ff[c]);
                     e2_in[c] = EDGE_W'(in_pos[c]) - EDGE_W'(hpos_ff[c]);
                     n2_in[c] = in_nrm[c];
                  end
                  du1_in = EDGE_W'(huv_ff[2]) - EDGE_W'(huv_ff[0]);
                  dv1_in = EDGE_W'(huv_ff[3]) - EDGE_W'(huv_ff[1]);
                  du2_in = EDGE_W'(req_bus.tex_u) - EDGE_W'(huv_ff[0]);
                  dv2_in = EDGE_W'(req_bus.tex_v) - EDGE_W'(huv_ff[1]);
                  k_in    = 2'd0;
                  idx_in  = 2'd0;
                  half_in = 1'b0;
               end else begin
                  vcnt_in = vcnt_ff + 2'd1;
                  for (int c = 0; c < 3; c++) begin
                     if (vcnt_ff == 2'd0) begin
                        hpos_in[c] = in_pos[c];
                        hnrm_in[c] = in_nrm[c];
                     end else begin
                        hpos_in[3+c] = in_pos[c];
                        hnrm_in[3+c] = in_nrm[c];
                     end
                  end
                  if (vcnt_ff == 2'd0) begin
                     huv_in[0] = req_bus.tex_u;
                     huv_in[1] = req_bus.tex_v;
                  end else begin
                     huv_in[2] = req_bus.tex_u;
                     huv_in[3] = req_bus.tex_v;
                  end
               end
            end
         end
         S_DET: begin
            if (alu_done) begin
               run_in  = alu_res;
               half_in = !half_ff;
               if (half_ff) begin
                  dneg_in = res_neg;
                  idx_in  = 2'd0;
                  if (alu_res == '0) begin
                     for (int c = 0; c < 3; c++) tu_in[c] = '0;
                  end
               end
            end
         end
         S_TAN: begin
            if (alu_done) begin
               run_in  = alu_res;
               half_in = !half_ff;
               if (half_ff) begin
                  mag_in[idx_ff] = res_abs[MAG_W-1:0];
                  neg_in[idx_ff] = res_neg ^ dneg_ff;
                  idx_in         = last_idx ? 2'd0 : idx_ff + 2'd1;
                  phase_in       = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            idx_in = 2'd0;
            if (orv == '0) begin
               if (phase_ff) begin
                  for (int c = 0; c < 3; c++) tu_in[c] = '0;
               end else begin
                  res_in[0] = NRM_W'(1) << NORM_FRAC_BITS;
                  res_in[1] = '0;
                  res_in[2] = '0;
               end
            end else if (|orv[MAG_W-1:TOP_BITS]) begin
               for (int c = 0; c < 3; c++) mag_in[c] = mag_ff[c] >> 1;
            end else if (!orv[TOP_BITS-1]) begin
               for (int c = 0; c < 3; c++) mag_in[c] = mag_ff[c] << 1;
            end
         end
         S_SQ: begin
            if (alu_done) begin
               run_in = alu_res;
               idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
            end
         end
         S_SQRT: begin
            if (alu_done) begin
               root_in = alu_res[ROOT_W-1:0];
               idx_in  = 2'd0;
            end
         end
         S_DIV: begin
            if (alu_done) begin
               if (phase_ff) tu_in[idx_ff] = neg_ff[idx_ff] ? -qt : qt;
               else res_in[idx_ff] = neg_ff[idx_ff] ? -qn : qn;
               idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
            end
         end
         S_PROJ: begin
            if (alu_done) begin
               run_in = alu_res;
               if (last_idx) proj_in = alu_res;
               idx_in = last_idx ? 2'd0 : idx_ff + 2'd1;
            end
         end
         S_WORTH: begin
            if (alu_done) begin
               mag_in[idx_ff] = res_abs[MAG_W-1:0];
               neg_in[idx_ff] = res_neg;
               idx_in         = last_idx ? 2'd0 : idx_ff + 2'd1;
               phase_in       = 1'b0;
            end
         end
         S_OUT: begin
            if (rsp_xfer) begin
               idx_in = 2'd0;
               k_in   = (k_ff == 2'd2) ? 2'd0 : k_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vcnt_ff   <= 2'd0;
         issued_ff <= 1'b0;
         idx_ff    <= 2'd0;
         half_ff   <= 1'b0;
         phase_ff  <= 1'b0;
         k_ff      <= 2'd0;
      end else begin
         state_ff  <= state_in;
         vcnt_ff   <= vcnt_in;
         issued_ff <= issued_in;
         idx_ff    <= idx_in;
         half_ff   <= half_in;
         phase_ff  <= phase_in;
         k_ff      <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      hpos_ff <= hpos_in;
      huv_ff  <= huv_in;
      hnrm_ff <= hnrm_in;
      n2_ff   <= n2_in;
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      du1_ff  <= du1_in;
      dv1_ff  <= dv1_in;
      du2_ff  <= du2_in;
      dv2_ff  <= dv2_in;
      dneg_ff <= dneg_in;
      run_ff  <= run_in;
      proj_ff <= proj_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      root_ff <= root_in;
      tu_ff   <= tu_in;
      res_ff  <= res_in;
   end

   `TTGS_AST_NOW(a_out_blocks_in, clock, reset, rsp_bus.valid, !req_bus.ready, "vertex taken while tangent pending")
   `TTGS_AST_NEXT(a_last_frees, clock, reset, rsp_xfer && rsp_bus.last_of_triangle, req_bus.ready, "not idle after last tangent")
   `TTGS_AST_NOW(a_start_idle_unit, clock, reset, alu_req.start, !alu_sts.busy && !alu_done, "unit restarted while working")

endmodule

FILE: hw/rtl/ttgs_alu.sv
// Shared bit-serial unit: multiply-accumulate, integer square root, divide.
// Depends on ttgs_pkg and the defines header.
`include "triangle_tangent_gram_schmidt_unit_defines.svh"

module ttgs_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  ttgs_pkg::alu_req_type      alu_req,
   input  logic [ttgs_pkg::ACC_W-1:0] opa,
   input  logic [ttgs_pkg::ACC_W-1:0] opb,
   input  logic [ttgs_pkg::ACC_W-1:0] init,
   output logic [ttgs_pkg::ACC_W-1:0] result,
   output ttgs_pkg::alu_sts_type      alu_sts
);
   import ttgs_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   alu_op_type       op_ff, op_in;
   logic             sub_ff, sub_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] a_ff, a_in;
   logic [ACC_W-1:0] b_ff, b_in;

   logic [ACC_W-1:0] addend, trial, shifted;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      sub_in  = sub_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      addend  = '0;
      trial   = '0;
      shifted = '0;
      ge      = 1'b0;
      if (alu_req.start) begin
         busy_in = 1'b1;
         op_in   = alu_req.op;
         sub_in  = alu_req.sub;
         case (alu_req.op)
            ALU_MAC: begin
               acc_in = init;
               a_in   = opa;
               b_in   = opb;
               cnt_in = CNT_W'(OPB_W - 1);
            end
            ALU_SQRT: begin
               acc_in = opa;
               a_in   = '0;
               b_in   = ACC_W'(1) << SQRT_TOP;
               cnt_in = CNT_W'(SQRT_N - 1);
            end
            default: begin
               acc_in = '0;
               a_in   = opa;
               b_in   = opb;
               cnt_in = CNT_W'(DIV_N - 1);
            end
         endcase
      end else if (busy_ff) begin
         case (op_ff)
            ALU_MAC: begin
               // top multiplier bit carries negative weight
               addend = (sub_ff ^ (cnt_ff == '0)) ? -a_ff : a_ff;
               if (b_ff[0]) acc_in = acc_ff + addend;
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
            end
            ALU_SQRT: begin
               trial = a_ff + b_ff;
               ge    = acc_ff >= trial;
               if (ge) begin
                  acc_in = acc_ff - trial;
                  a_in   = (a_ff >> 1) + b_ff;
               end else begin
                  a_in = a_ff >> 1;
               end
               b_in = b_ff >> 2;
            end
            default: begin
               shifted = {acc_ff[ACC_W-2:0], a_ff[DIV_N-1]};
               ge      = shifted >= b_ff;
               acc_in  = ge ? shifted - b_ff : shifted;
               a_in    = {a_ff[ACC_W-2:0], ge};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MAC;
         sub_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         sub_ff  <= sub_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   always_comb begin
      case (op_ff)
         ALU_MAC:  result = acc_ff;
         ALU_SQRT: result = a_ff;
         default:  result = {{(ACC_W - DIV_N){1'b0}}, a_ff[DIV_N-1:0]};
      endcase
   end

   assign alu_sts.busy = busy_ff;
   assign alu_sts.done = done_ff;

   `TTGS_AST_NEXT(a_start_busy, clock, reset, alu_req.start, busy_ff, "start did not raise busy")
   `TTGS_AST_NOW(a_done_end, clock, reset, done_ff, $past(busy_ff) && !busy_ff, "stray done")
   `TTGS_AST_NOW(a_no_start_busy, clock, reset, alu_req.start, !busy_ff, "start while busy")

endmodule
